// ===== rtl/mmt_pkg.sv =====
// shared types, event codes, midi constants and the controller map
// for the mus to midi event transcoder; no dependencies
package mmt_pkg;

    localparam int MaxBytes = 7;
    localparam int CntW = 3;
    localparam int TickW = 28;
    localparam int CountW = 32;

    typedef struct packed {
        logic       action;
        logic [7:0] mus_byte;
    } t_mmt_in;

    typedef struct packed {
        logic [7:0]  midi_byte;
        logic        last;
        logic        end_of_track;
        logic        format_error;
        logic [31:0] track_length;
    } t_mmt_out;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [CntW-1:0]          cnt;
        logic                     eot;
        logic                     err;
        logic [CountW-1:0]        len;
    } t_mmt_load;

    typedef enum logic [3:0] {
        PH_DESC,
        PH_RELKEY,
        PH_PRESSKEY,
        PH_PRESSVEL,
        PH_PITCH,
        PH_SYSCTL,
        PH_CTLNUM,
        PH_CTLVAL,
        PH_DELAY,
        PH_DONE,
        PH_HALT
    } t_phase;

    localparam logic [2:0] EV_RELEASE   = 3'd0;
    localparam logic [2:0] EV_PRESS     = 3'd1;
    localparam logic [2:0] EV_PITCH     = 3'd2;
    localparam logic [2:0] EV_SYSTEM    = 3'd3;
    localparam logic [2:0] EV_CONTROL   = 3'd4;
    localparam logic [2:0] EV_SCORE_END = 3'd6;

    localparam logic [7:0] ST_NOTE_OFF       = 8'h80;
    localparam logic [7:0] ST_NOTE_ON        = 8'h90;
    localparam logic [7:0] ST_CONTROL_CHANGE = 8'hB0;
    localparam logic [7:0] ST_PROGRAM_CHANGE = 8'hC0;
    localparam logic [7:0] ST_PITCH_BEND     = 8'hE0;
    localparam logic [7:0] MIDI_META         = 8'hFF;
    localparam logic [7:0] MIDI_META_EOT     = 8'h2F;

    localparam logic [3:0] CHAN_PERC_MUS  = 4'd15;
    localparam logic [3:0] CHAN_PERC_MIDI = 4'd9;
    localparam logic [7:0] SYS_FIRST      = 8'd10;
    localparam logic [7:0] SYS_LAST       = 8'd14;
    localparam logic [7:0] CTL_LAST       = 8'd9;
    localparam logic [3:0] CTL_PATCH      = 4'd0;

    localparam logic [TickW-1:0]  TICK_MAX  = '1;
    localparam logic [CountW-1:0] COUNT_MAX = '1;

    function automatic logic [7:0] ctl_map(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h20;
            4'd2:    v = 8'h01;
            4'd3:    v = 8'h07;
            4'd4:    v = 8'h0A;
            4'd5:    v = 8'h0B;
            4'd6:    v = 8'h5B;
            4'd7:    v = 8'h5D;
            4'd8:    v = 8'h40;
            4'd9:    v = 8'h43;
            4'd10:   v = 8'h78;
            4'd11:   v = 8'h7B;
            4'd12:   v = 8'h7E;
            4'd13:   v = 8'h7F;
            4'd14:   v = 8'h79;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/mus_to_midi_event_transcoder_unit.sv =====
// mus score to midi track transcoder, top level
// a score byte is registered in mmt_in_stage, then its track bytes in mmt_out_queue
// throughput: one score byte per cycle while no result is queued; a byte that gives
// results holds the queue to its last track byte, one per cycle unless i_out_stall
// reset: synchronous active low, clears parse state, counts, time, velocities to 127
// depends on mmt_pkg, mmt_in_stage, mmt_decoder, mmt_out_queue
module mus_to_midi_event_transcoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mmt_pkg::t_mmt_in  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mmt_pkg::t_mmt_out o_out_res
);
    import mmt_pkg::*;

    logic      item_valid;
    t_mmt_in   item;
    logic      q_free;
    logic      go;
    t_mmt_load load;

    assign go = item_valid && q_free;

    mmt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (i_in_req),
        .i_take  (go),
        .o_valid (item_valid),
        .o_item  (item)
    );

    mmt_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (item),
        .o_load  (load)
    );

    mmt_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load_en (go),
        .i_load    (load),
        .o_free    (q_free),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_res     (o_out_res)
    );

endmodule

// ===== rtl/mmt_in_stage.sv =====
// input register for score byte requests
// depends on mmt_pkg
module mmt_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mmt_pkg::t_mmt_in i_req,
    input  logic             i_take,
    output logic             o_valid,
    output mmt_pkg::t_mmt_in o_item
);
    import mmt_pkg::*;

    logic    r_valid, n_valid;
    t_mmt_in r_item;
    logic    accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_req;
        end
    end

endmodule

// ===== rtl/mmt_decoder.sv =====
// mus event parser: parse state, channel velocities, queued time and byte count,
// builds the list of track bytes for one score byte; depends on mmt_pkg
module mmt_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  mmt_pkg::t_mmt_in   i_item,
    output mmt_pkg::t_mmt_load o_load
);
    import mmt_pkg::*;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_chan, n_chan;
    logic [7:0]        r_key, n_key;
    logic [3:0]        r_ctl, n_ctl;
    logic              r_group, n_group;
    logic [TickW-1:0]  r_dacc, n_dacc;
    logic [TickW-1:0]  r_pend, n_pend;
    logic [6:0]        r_vel [16];
    logic              vel_we;
    logic [CountW-1:0] r_count, n_count;

    logic [7:0]        b;
    logic              restart;
    logic [2:0]        ev;
    logic [3:0]        sw_ch;
    t_phase            ph_done;
    logic [TickW-1:0]  acc_next;
    logic [TickW:0]    pend_sum;
    logic [TickW-1:0]  pend_sat;
    logic [6:0]        grp [4];
    logic [2:0]        tn;
    logic              has_msg, err, eot;
    logic [1:0]        mlen;
    logic [7:0]        m [3];
    logic [CntW-1:0]   cnt;
    logic [CountW:0]   count_sum;
    logic [CountW-1:0] count_sat;

    assign b       = i_item.mus_byte;
    assign restart = i_item.action;
    assign ev      = b[6:4];
    assign sw_ch   = (b[3:0] == CHAN_PERC_MUS)  ? CHAN_PERC_MIDI :
                     (b[3:0] == CHAN_PERC_MIDI) ? CHAN_PERC_MUS  : b[3:0];
    assign ph_done = r_group ? PH_DELAY : PH_DESC;

    assign acc_next  = (r_dacc[TickW-1:TickW-7] != 7'd0) ? TICK_MAX
                                                         : {r_dacc[TickW-8:0], b[6:0]};
    assign pend_sum  = {1'b0, r_pend} + {1'b0, acc_next};
    assign pend_sat  = pend_sum[TickW] ? TICK_MAX : pend_sum[TickW-1:0];

    assign grp[0] = r_pend[6:0];
    assign grp[1] = r_pend[13:7];
    assign grp[2] = r_pend[20:14];
    assign grp[3] = r_pend[27:21];
    assign tn = (grp[3] != 7'd0) ? 3'd4 :
                (grp[2] != 7'd0) ? 3'd3 :
                (grp[1] != 7'd0) ? 3'd2 : 3'd1;

    // message bytes and error flag for this score byte
    always_comb begin
        has_msg = 1'b0;
        err     = 1'b0;
        eot     = 1'b0;
        mlen    = 2'd3;
        m[0]    = 8'h00;
        m[1]    = 8'h00;
        m[2]    = 8'h00;
        if (i_go && !restart) begin
            case (r_phase)
                PH_DESC: begin
                    case (ev)
                        EV_RELEASE, EV_PRESS, EV_PITCH, EV_SYSTEM, EV_CONTROL: begin
                        end
                        EV_SCORE_END: begin
                            has_msg = 1'b1;
                            eot     = 1'b1;
                            m[0]    = MIDI_META;
                            m[1]    = MIDI_META_EOT;
                        end
                        default: err = 1'b1;
                    endcase
                end
                PH_RELKEY: begin
                    has_msg = 1'b1;
                    m[0]    = ST_NOTE_OFF | {4'h0, r_chan};
                    m[1]    = {1'b0, b[6:0]};
                end
                PH_PRESSKEY: begin
                    if (!b[7]) begin
                        has_msg = 1'b1;
                        m[0]    = ST_NOTE_ON | {4'h0, r_chan};
                        m[1]    = {1'b0, b[6:0]};
                        m[2]    = {1'b0, r_vel[r_chan]};
                    end
                end
                PH_PRESSVEL: begin
                    has_msg = 1'b1;
                    m[0]    = ST_NOTE_ON | {4'h0, r_chan};
                    m[1]    = {1'b0, r_key[6:0]};
                    m[2]    = {1'b0, b[6:0]};
                end
                PH_PITCH: begin
                    has_msg = 1'b1;
                    m[0]    = ST_PITCH_BEND | {4'h0, r_chan};
                    m[1]    = {1'b0, b[0], 6'd0};
                    m[2]    = {1'b0, b[7:1]};
                end
                PH_SYSCTL: begin
                    if (b < SYS_FIRST || b > SYS_LAST) begin
                        err = 1'b1;
                    end else begin
                        has_msg = 1'b1;
                        m[0]    = ST_CONTROL_CHANGE | {4'h0, r_chan};
                        m[1]    = ctl_map(b[3:0]);
                    end
                end
                PH_CTLNUM: begin
                    err = (b > CTL_LAST);
                end
                PH_CTLVAL: begin
                    has_msg = 1'b1;
                    if (r_ctl == CTL_PATCH) begin
                        mlen = 2'd2;
                        m[0] = ST_PROGRAM_CHANGE | {4'h0, r_chan};
                        m[1] = {1'b0, b[6:0]};
                    end else begin
                        m[0] = ST_CONTROL_CHANGE | {4'h0, r_chan};
                        m[1] = ctl_map(r_ctl);
                        m[2] = b[7] ? 8'h7F : b;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign cnt       = has_msg ? CntW'(tn + {1'b0, mlen}) : (err ? CntW'(1) : '0);
    assign count_sum = {1'b0, r_count} + {{(CountW+1-CntW){1'b0}}, cnt};
    assign count_sat = count_sum[CountW] ? COUNT_MAX : count_sum[CountW-1:0];

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (i_go) begin
            if (restart) begin
                n_phase = PH_DESC;
            end else begin
                case (r_phase)
                    PH_DESC: begin
                        case (ev)
                            EV_RELEASE:   n_phase = PH_RELKEY;
                            EV_PRESS:     n_phase = PH_PRESSKEY;
                            EV_PITCH:     n_phase = PH_PITCH;
                            EV_SYSTEM:    n_phase = PH_SYSCTL;
                            EV_CONTROL:   n_phase = PH_CTLNUM;
                            EV_SCORE_END: n_phase = PH_DONE;
                            default:      n_phase = PH_HALT;
                        endcase
                    end
                    PH_RELKEY:   n_phase = ph_done;
                    PH_PRESSKEY: n_phase = b[7] ? PH_PRESSVEL : ph_done;
                    PH_PRESSVEL: n_phase = ph_done;
                    PH_PITCH:    n_phase = ph_done;
                    PH_SYSCTL:   n_phase = (b < SYS_FIRST || b > SYS_LAST) ? PH_HALT : ph_done;
                    PH_CTLNUM:   n_phase = (b > CTL_LAST) ? PH_HALT : PH_CTLVAL;
                    PH_CTLVAL:   n_phase = ph_done;
                    PH_DELAY:    n_phase = b[7] ? PH_DELAY : PH_DESC;
                    default:     n_phase = r_phase;
                endcase
            end
        end
    end

    // parse data, queued time and count
    always_comb begin
        n_chan  = r_chan;
        n_key   = r_key;
        n_ctl   = r_ctl;
        n_group = r_group;
        n_dacc  = r_dacc;
        n_pend  = r_pend;
        n_count = r_count;
        vel_we  = 1'b0;
        if (i_go) begin
            if (restart) begin
                n_chan  = '0;
                n_key   = '0;
                n_ctl   = '0;
                n_group = 1'b0;
                n_dacc  = '0;
                n_pend  = '0;
                n_count = '0;
            end else begin
                if (has_msg) begin
                    n_pend  = '0;
                    n_count = count_sat;
                end
                case (r_phase)
                    PH_DESC: begin
                        n_chan  = sw_ch;
                        n_group = b[7];
                    end
                    PH_PRESSKEY: n_key = b;
                    PH_PRESSVEL: vel_we = 1'b1;
                    PH_CTLNUM: begin
                        if (!err) begin
                            n_ctl = b[3:0];
                        end
                    end
                    PH_DELAY: begin
                        n_dacc = acc_next;
                        if (!b[7]) begin
                            n_pend = pend_sat;
                            n_dacc = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // byte list: delta time groups high first, then the message
    always_comb begin
        logic [2:0] gi;
        logic [2:0] mi;
        o_load.bytes = '0;
        for (int k = 0; k < MaxBytes; k++) begin
            gi = 3'(tn - 3'(k) - 3'd1);
            mi = 3'(3'(k) - tn);
            if (has_msg) begin
                if (3'(k) < tn) begin
                    o_load.bytes[k] = {(3'(k) != 3'(tn - 3'd1)), grp[gi[1:0]]};
                end else if (mi < 3'd3) begin
                    o_load.bytes[k] = m[mi[1:0]];
                end
            end
        end
        o_load.cnt = cnt;
        o_load.eot = eot;
        o_load.err = err;
        o_load.len = count_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DESC;
            r_chan  <= '0;
            r_key   <= '0;
            r_ctl   <= '0;
            r_group <= 1'b0;
            r_dacc  <= '0;
            r_pend  <= '0;
            r_count <= '0;
            for (int i = 0; i < 16; i++) begin
                r_vel[i] <= 7'h7F;
            end
        end else begin
            r_phase <= n_phase;
            r_chan  <= n_chan;
            r_key   <= n_key;
            r_ctl   <= n_ctl;
            r_group <= n_group;
            r_dacc  <= n_dacc;
            r_pend  <= n_pend;
            r_count <= n_count;
            if (vel_we) begin
                r_vel[r_chan] <= b[6:0];
            end
        end
    end

    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_go |=> $stable(r_phase))
        else $error("parse phase moved without a request");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load.err |-> (o_load.cnt == CntW'(1)) && !o_load.eot)
        else $error("format error not a lone result");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) && i_go && !i_item.action |=> (r_phase == PH_HALT))
        else $error("left halt without restart");

    a_eot_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load.eot |-> (o_load.cnt >= CntW'(4)))
        else $error("end of track without delta time and marker");

endmodule

// ===== rtl/mmt_out_queue.sv =====
// result byte queue: holds the bytes of one request and shifts them out
// depends on mmt_pkg
module mmt_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_en,
    input  mmt_pkg::t_mmt_load i_load,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_stall,
    output mmt_pkg::t_mmt_out  o_res
);
    import mmt_pkg::*;

    logic [MaxBytes-1:0][7:0] r_bytes, n_bytes;
    logic [CntW-1:0]          r_cnt, n_cnt;
    logic                     r_eot, n_eot;
    logic                     r_err, n_err;
    logic [CountW-1:0]        r_len, n_len;
    logic                     take;
    logic                     is_last;

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && !i_stall;
    assign is_last = (r_cnt == CntW'(1));
    assign o_free  = (r_cnt == '0) || (is_last && !i_stall);

    assign o_res.midi_byte    = r_bytes[0];
    assign o_res.last         = is_last;
    assign o_res.end_of_track = r_eot && is_last;
    assign o_res.format_error = r_err;
    assign o_res.track_length = (r_eot && is_last) ? r_len : '0;

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        n_eot   = r_eot;
        n_err   = r_err;
        n_len   = r_len;
        if (i_load_en) begin
            n_bytes = i_load.bytes;
            n_cnt   = i_load.cnt;
            n_eot   = i_load.eot;
            n_err   = i_load.err;
            n_len   = i_load.len;
        end else if (take) begin
            n_bytes = {8'h00, r_bytes[MaxBytes-1:1]};
            n_cnt   = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_eot   <= n_eot;
        r_err   <= n_err;
        r_len   <= n_len;
    end

endmodule
